// ===== sv/icy_stream_metadata_demux_macros.svh =====
// Assertion macros for the ICY metadata demux.
`ifndef ICY_STREAM_METADATA_DEMUX_MACROS_SVH
`define ICY_STREAM_METADATA_DEMUX_MACROS_SVH
// Check that a condition implies another on the same edge.
`define ICY_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Check that a condition implies another on the next edge.
`define ICY_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// ===== sv/icy_pkg.sv =====
// Shared types and constants for the ICY metadata demux.
`timescale 1ns / 1ps
package icy_pkg;
    localparam logic [1:0] KIND_AUDIO  = 2'd0;
    localparam logic [1:0] KIND_ARTIST = 2'd1;
    localparam logic [1:0] KIND_TITLE  = 2'd2;

    localparam logic [1:0] CFG_ENABLE   = 2'd0;
    localparam logic [1:0] CFG_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_INITIAL  = 2'd2;

    localparam logic [1:0] PS_INIT   = 2'd0;
    localparam logic [1:0] PS_OTHER  = 2'd1;
    localparam logic [1:0] PS_ARTIST = 2'd2;
    localparam logic [1:0] PS_TITLE  = 2'd3;

    localparam int KEY_LEN = 11;
    localparam int MAX_RUN = 64;

    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "S";
            4'd1:    c = "t";
            4'd2:    c = "r";
            4'd3:    c = "e";
            4'd4:    c = "a";
            4'd5:    c = "m";
            4'd6:    c = "T";
            4'd7:    c = "i";
            4'd8:    c = "t";
            4'd9:    c = "l";
            4'd10:   c = "e";
            default: c = 8'd0;
        endcase
        return c;
    endfunction
endpackage

// ===== sv/icy_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module icy_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/icy_stream_metadata_demux.sv =====
// ICY stream metadata demux: payload/metadata split and StreamTitle parser.
// Audio beats are registered, valid in the cycle after acceptance. Throughput:
// one byte per cycle while the output is free; a byte ending a text run stops
// intake while the run is read from RAM and output, then a full-store byte is
// replayed. Reset (synchronous, active low) sets control registers to defaults;
// text RAM is not cleared, only entries below the fill count are read.
`timescale 1ns / 1ps
module icy_stream_metadata_demux
    import icy_pkg::*;
#(
    parameter int TEXT_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] data_byte
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast
);
    localparam int AW = $clog2(TEXT_BYTES);
    localparam int FW = $clog2(TEXT_BYTES + 1);
    localparam int CW = FW + 2;

    typedef enum logic [2:0] {
        ST_RUN  = 3'b001,
        ST_EMIT = 3'b010,
        ST_PEND = 3'b100
    } t_state;

    t_state      r_state, n_state;
    logic        r_en;
    logic [15:0] r_interval, r_pcount, n_pcount;
    logic        r_meta, n_meta;
    logic [11:0] r_remain, n_remain;
    logic [1:0]  r_ps, n_ps;
    logic [FW-1:0] r_fill, n_fill;
    logic        r_match, n_match;
    logic [7:0]  r_h1, r_h2, n_h1, n_h2; // last two stored bytes
    // run readout
    logic [AW-1:0] r_ridx, n_ridx;
    logic [6:0]  r_rlen, n_rlen;
    logic [6:0]  r_rcnt, n_rcnt;
    logic [1:0]  r_rkind, n_rkind;
    logic        r_rdv, n_rdv;
    logic        r_pend_b, n_pend_b;   // byte must be reprocessed after store-full run
    logic [7:0]  r_pbyte, n_pbyte;
    // output register
    logic        r_ov, n_ov;
    logic [7:0]  r_od, n_od;
    logic [1:0]  r_ok, n_ok;
    logic        r_ol, n_ol;
    // ram
    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]  wdata, rdata;

    icy_ram #(.WIDTH(8), .DEPTH(TEXT_BYTES)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic out_free, acc;
    logic [7:0] b;
    logic [6:0] cap;

    assign out_free      = !r_ov || m_axis_tready;
    assign s_axis_tready = (r_state == ST_RUN) && out_free;
    assign o_cfg_ready   = 1'b1;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
    assign m_axis_tuser  = r_ok;
    assign m_axis_tlast  = r_ol;
    assign raddr         = r_ridx;

    // parse one byte; may start a run
    logic [FW-1:0] p_fill;
    logic [1:0]    p_ps;
    logic          p_match;
    logic [7:0]    p_h1, p_h2;
    logic          run_go;
    logic [6:0]    run_len;
    logic [1:0]    run_kind;

    always_comb begin
        n_state = r_state;
        n_pcount = r_pcount; n_meta = r_meta; n_remain = r_remain;
        n_ps = r_ps; n_fill = r_fill; n_match = r_match; n_h1 = r_h1; n_h2 = r_h2;
        n_ridx = r_ridx; n_rlen = r_rlen; n_rcnt = r_rcnt; n_rkind = r_rkind;
        n_rdv = 1'b0; n_pend_b = r_pend_b; n_pbyte = r_pbyte;
        n_ov = r_ov && !m_axis_tready; n_od = r_od; n_ok = r_ok; n_ol = r_ol;
        we = 1'b0; waddr = r_fill[AW-1:0]; wdata = 8'd0;
        b = (r_state == ST_PEND) ? r_pbyte : s_axis_tdata;
        p_fill = r_fill; p_ps = r_ps; p_match = r_match; p_h1 = r_h1; p_h2 = r_h2;
        run_go = 1'b0; run_len = '0; run_kind = KIND_ARTIST;
        cap = (TEXT_BYTES - 1 > MAX_RUN) ? 7'(MAX_RUN) : 7'(TEXT_BYTES - 1);

        if (acc || r_state == ST_PEND) begin
            if (!r_en) begin
                n_ov = 1'b1; n_od = b; n_ok = KIND_AUDIO; n_ol = 1'b1;
            end else if (!r_meta && r_state == ST_RUN) begin
                if (r_pcount >= r_interval) begin
                    n_remain = {b, 4'd0};
                    n_pcount = '0;
                    n_meta = (b != 8'd0);
                end else begin
                    n_ov = 1'b1; n_od = b; n_ok = KIND_AUDIO; n_ol = 1'b1;
                    n_pcount = r_pcount + 16'd1;
                end
            end else begin
                // metadata byte
                if (b != 8'd0 && !(r_ps == PS_OTHER)) begin
                    if (r_fill == FW'(TEXT_BYTES) && r_state == ST_RUN
                        && (r_ps == PS_ARTIST || r_ps == PS_TITLE)) begin
                        run_go = 1'b1; run_len = cap;
                        run_kind = (r_ps == PS_ARTIST) ? KIND_ARTIST : KIND_TITLE;
                        n_pend_b = 1'b1; n_pbyte = b;
                        n_ps = PS_INIT; n_fill = '0; n_match = 1'b1;
                    end else begin
                        if (r_state == ST_PEND) begin
                            p_ps = PS_INIT; p_fill = '0; p_match = 1'b1;
                        end else if (r_fill == FW'(TEXT_BYTES)) begin
                            p_ps = PS_INIT; p_fill = '0; p_match = 1'b1;
                        end
                        if (p_ps == PS_INIT) begin
                            if (p_fill < FW'(KEY_LEN))
                                p_match = p_match && (b == key_char(p_fill[3:0]));
                            else if (p_fill == FW'(KEY_LEN))
                                p_match = p_match && (b == "=");
                        end
                        we = 1'b1; waddr = p_fill[AW-1:0]; wdata = b;
                        n_fill = p_fill + FW'(1); n_ps = p_ps; n_match = p_match;
                        n_h2 = p_h1; n_h1 = b;
                        case (p_ps)
                            PS_INIT: begin
                                if (b == "'" && p_fill >= FW'(1) && p_h1 == "=") begin
                                    n_ps = (p_match && p_fill == FW'(KEY_LEN + 1))
                                        ? PS_ARTIST : PS_OTHER;
                                    n_fill = '0; n_match = 1'b1;
                                end
                            end
                            PS_ARTIST: begin
                                if (b == " " && p_fill >= FW'(2) && p_h1 == "-"
                                    && p_h2 == " ") begin
                                    run_go = 1'b1; run_kind = KIND_ARTIST;
                                    run_len = (CW'(p_fill) - CW'(2) > CW'(MAX_RUN)) ?
                                        7'(MAX_RUN) : 7'(p_fill - FW'(2));
                                    n_ps = PS_TITLE; n_fill = '0;
                                end
                            end
                            default: begin
                                if (b == ";" && p_fill >= FW'(1) && p_h1 == "'") begin
                                    run_go = 1'b1; run_kind = KIND_TITLE;
                                    run_len = (CW'(p_fill) - CW'(1) > CW'(MAX_RUN)) ?
                                        7'(MAX_RUN) : 7'(p_fill - FW'(1));
                                    n_ps = PS_INIT; n_fill = '0; n_match = 1'b1;
                                end
                            end
                        endcase
                        n_pend_b = 1'b0;
                    end
                end else if (b != 8'd0 && b == ";") begin
                    n_ps = PS_INIT; n_fill = '0; n_match = 1'b1;
                end
                if (r_state == ST_RUN) begin
                    n_remain = (r_remain > 12'd0) ? r_remain - 12'd1 : r_remain;
                    if (n_remain == 12'd0) begin
                        n_pcount = '0; n_meta = 1'b0;
                    end
                end
                if (run_go && run_len != 7'd0) begin
                    n_state = ST_EMIT; n_ridx = '0; n_rlen = run_len; n_rcnt = '0;
                    n_rkind = run_kind; n_rdv = 1'b0;
                end else if (n_pend_b) begin
                    n_state = ST_PEND;
                end else begin
                    n_state = ST_RUN;
                end
            end
        end else if (r_state == ST_EMIT) begin
            // issue reads, one beat at a time into the output register
            if (r_rdv && out_free) begin
                n_ov = 1'b1; n_od = rdata; n_ok = r_rkind;
                n_ol = (r_rcnt + 7'd1 == r_rlen);
                n_rcnt = r_rcnt + 7'd1;
                if (r_rcnt + 7'd1 == r_rlen)
                    n_state = r_pend_b ? ST_PEND : ST_RUN;
                else begin
                    n_ridx = r_ridx + AW'(1);
                end
            end else if (!r_rdv) begin
                n_rdv = 1'b1;
            end else begin
                n_rdv = 1'b1;
            end
            if (r_rdv && out_free && r_rcnt + 7'd1 != r_rlen)
                n_rdv = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN; r_en <= 1'b0; r_interval <= 16'd16000;
            r_pcount <= '0; r_meta <= 1'b0; r_remain <= '0;
            r_ps <= PS_INIT; r_fill <= '0; r_match <= 1'b1; r_rdv <= 1'b0;
            r_pend_b <= 1'b0; r_ov <= 1'b0; r_rcnt <= '0; r_rlen <= '0;
            r_ridx <= '0; r_rkind <= KIND_ARTIST;
        end else begin
            r_state <= n_state; r_meta <= n_meta;
            r_remain <= n_remain; r_ps <= n_ps; r_fill <= n_fill; r_match <= n_match;
            r_rdv <= n_rdv; r_pend_b <= n_pend_b; r_ov <= n_ov; r_rcnt <= n_rcnt;
            r_rlen <= n_rlen; r_ridx <= n_ridx; r_rkind <= n_rkind;
            if (i_cfg_valid && i_cfg_index == CFG_INITIAL) begin
                r_pcount <= i_cfg_data;
            end else begin
                r_pcount <= n_pcount;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ENABLE:   r_en <= i_cfg_data[0];
                    CFG_INTERVAL: r_interval <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_h1 <= n_h1; r_h2 <= n_h2; r_pbyte <= n_pbyte;
        r_od <= n_od; r_ok <= n_ok; r_ol <= n_ol;
    end

    `include "icy_stream_metadata_demux_macros.svh"

    `ICY_ASSERT_IMPL(a_no_take_emit, i_clk, i_rst_n, r_state != ST_RUN, !s_axis_tready)
    `ICY_ASSERT_IMPL(a_fill_range, i_clk, i_rst_n, 1'b1, r_fill <= FW'(TEXT_BYTES))
    `ICY_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_ov && !m_axis_tready,
        r_ov && $stable(r_od) && $stable(r_ok) && $stable(r_ol))
endmodule
